@@ sv/lwm_pkg.sv @@
`timescale 1ns / 1ps

package lwm_pkg;

	typedef struct packed {
		logic signed [30:0] latitude;
		logic signed [31:0] longitude;
	} point_t;

	typedef struct packed {
		logic signed [31:0] x_cm;
		logic signed [31:0] y_cm;
		logic               out_of_range;
	} merc_t;

	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam logic [63:0] LN2_Q60  = 64'h0B17217F7D1CF79B;
	localparam logic [63:0] HALF_Q60 = 64'h0800000000000000;
	localparam logic [63:0] QPI_Q60  = PI_Q60 >> 2;
	localparam logic [63:0] R_CM     = 64'd637813700;

	localparam logic signed [30:0] LAT_LIMIT = 31'sd850511000;
	localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;

	localparam logic [63:0] DEG_DIV = 64'd3600000000;
	localparam logic [63:0] RAD_Q   = PI_Q60 / DEG_DIV;
	localparam logic [63:0] RAD_R   = PI_Q60 % DEG_DIV;
	// degree (1e-7) to half-angle radian factor, Q60 scaled by 2^30
	localparam logic [63:0] RAD_F   = (RAD_Q << 30) + ((RAD_R << 30) / DEG_DIV);
	localparam logic [63:0] RAD_F2  = RAD_F << 1;
	localparam logic [63:0] F_HI    = RAD_F >> 32;
	localparam logic [63:0] F_LO    = RAD_F & 64'hFFFFFFFF;
	localparam logic [63:0] F2_HI   = RAD_F2 >> 32;
	localparam logic [63:0] F2_LO   = RAD_F2 & 64'hFFFFFFFF;

	function automatic logic [63:0] div_odd(input logic [63:0] v, input int k);
		logic [63:0] r;
		case (k)
			1: r = v / 3;
			2: r = v / 5;
			3: r = v / 7;
			4: r = v / 9;
			5: r = v / 11;
			6: r = v / 13;
			7: r = v / 15;
			8: r = v / 17;
			9: r = v / 19;
			10: r = v / 21;
			11: r = v / 23;
			12: r = v / 25;
			13: r = v / 27;
			14: r = v / 29;
			15: r = v / 31;
			16: r = v / 33;
			17: r = v / 35;
			18: r = v / 37;
			19: r = v / 39;
			20: r = v / 41;
			21: r = v / 43;
			22: r = v / 45;
			23: r = v / 47;
			24: r = v / 49;
			25: r = v / 51;
			26: r = v / 53;
			27: r = v / 55;
			28: r = v / 57;
			29: r = v / 59;
			default: r = v;
		endcase
		return r;
	endfunction

	// truncated power series, atan when alt is set, atanh otherwise
	function automatic logic [63:0] series(input int i, input bit alt);
		logic [63:0] s;
		logic [63:0] term;
		int e;
		s = '0;
		for (int k = 0; k < 31; k++) begin
			e = i * (2 * k + 1);
			if (e <= 60) begin
				term = div_odd(64'd1 << (60 - e), k);
				if (alt && k[0]) s = s - term;
				else s = s + term;
			end
		end
		return s;
	endfunction

	function automatic logic [63:0] atan_entry(input int i);
		logic [63:0] r;
		if (i == 0) r = QPI_Q60;
		else r = series(i, 1'b1);
		return r;
	endfunction

	function automatic logic [63:0] atanh_entry(input int i);
		logic [63:0] r;
		if (i == 0) r = '0;
		else r = series(i, 1'b0);
		return r;
	endfunction

	function automatic int hyp_count(input int steps);
		int n;
		n = steps;
		if (steps >= 4) n++;
		if (steps >= 13) n++;
		if (steps >= 40) n++;
		return n;
	endfunction

	// shift index of hyperbolic stage k, with steps 4, 13 and 40 repeated
	function automatic int hyp_shift(input int k);
		int n;
		int r;
		n = 0;
		r = 64;
		for (int i = 1; i <= 64; i++) begin
			if (n == k && r == 64) r = i;
			n++;
			if (i == 4 || i == 13 || i == 40) begin
				if (n == k && r == 64) r = i;
				n++;
			end
		end
		return r;
	endfunction

endpackage

@@ sv/lwm_circ.sv @@
`timescale 1ns / 1ps

module lwm_circ
	import lwm_pkg::*;
#(
	parameter int STEPS = 32
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] theta,
	output logic [63:0] cos_v,
	output logic [63:0] sin_v
);

	logic [63:0] cx_s [STEPS];
	logic [63:0] cy_s [STEPS];
	logic [63:0] cz_s [STEPS];

	genvar k;
	for (k = 0; k < STEPS; k++) begin : g_st
		localparam logic [63:0] ANG = atan_entry(k);
		logic [63:0] xin, yin, zin, xs, ys;
		if (k == 0) begin : g_first
			assign xin = HALF_Q60;
			assign yin = '0;
			assign zin = theta;
		end else begin : g_next
			assign xin = cx_s[k-1];
			assign yin = cy_s[k-1];
			assign zin = cz_s[k-1];
		end
		assign xs = $signed(xin) >>> k;
		assign ys = $signed(yin) >>> k;
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zin[63]) begin
					cx_s[k] <= xin - ys;
					cy_s[k] <= yin + xs;
					cz_s[k] <= zin - ANG;
				end else begin
					cx_s[k] <= xin + ys;
					cy_s[k] <= yin - xs;
					cz_s[k] <= zin + ANG;
				end
			end
		end
	end

	assign cos_v = cx_s[STEPS-1];
	assign sin_v = cy_s[STEPS-1];

endmodule

@@ sv/lwm_norm.sv @@
`timescale 1ns / 1ps

module lwm_norm
	import lwm_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] sin_v,
	input  logic [63:0] cos_v,
	output logic [63:0] hx,
	output logic [63:0] hy,
	output logic [7:0]  dsh
);

	logic [63:0] vs_s1, vc_s1;
	logic [5:0]  ps_s1, pc_s1;
	logic [63:0] ms_s2, mc_s2;
	logic [6:0]  as_s2, ac_s2;
	logic [63:0] hx_s3, hy_s3;
	logic [7:0]  dsh_s3;

	function automatic logic [63:0] fix(input logic [63:0] v);
		logic [63:0] r;
		if (v == '0 || v[63]) r = 64'd1;
		else r = v;
		return r;
	endfunction

	function automatic logic [5:0] msb(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int b = 0; b < 63; b++) begin
			if (v[b]) p = 6'(b);
		end
		return p;
	endfunction

	function automatic logic [63:0] mant(input logic [63:0] v, input logic [5:0] p);
		logic [63:0] r;
		if (p >= 6'd59) r = v >> (p - 6'd59);
		else r = v << (6'd59 - p);
		return r;
	endfunction

	// leading one search
	always_ff @(posedge clk) begin
		if (en) begin
			vs_s1 <= fix(sin_v);
			vc_s1 <= fix(cos_v);
			ps_s1 <= msb(fix(sin_v));
			pc_s1 <= msb(fix(cos_v));
		end
	end

	// shift into [0.5, 1)
	always_ff @(posedge clk) begin
		if (en) begin
			ms_s2 <= mant(vs_s1, ps_s1);
			mc_s2 <= mant(vc_s1, pc_s1);
			as_s2 <= 7'd59 - {1'b0, ps_s1};
			ac_s2 <= 7'd59 - {1'b0, pc_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s3  <= ms_s2 + mc_s2;
			hy_s3  <= ms_s2 - mc_s2;
			dsh_s3 <= {ac_s2[6], ac_s2} - {as_s2[6], as_s2};
		end
	end

	assign hx  = hx_s3;
	assign hy  = hy_s3;
	assign dsh = dsh_s3;

endmodule

@@ sv/lwm_hyp.sv @@
`timescale 1ns / 1ps

module lwm_hyp
	import lwm_pkg::*;
#(
	parameter int STEPS = 32
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] hx,
	input  logic [63:0] hy,
	input  logic [7:0]  dsh_in,
	output logic [63:0] hz,
	output logic [7:0]  dsh_out
);

	localparam int NH = hyp_count(STEPS);

	logic [63:0] hx_s [NH];
	logic [63:0] hy_s [NH];
	logic [63:0] hz_s [NH];
	logic [7:0]  d_s  [NH];

	genvar k;
	for (k = 0; k < NH; k++) begin : g_st
		localparam int SH = hyp_shift(k);
		localparam logic [63:0] ANG = atanh_entry(SH);
		logic [63:0] xin, yin, zin, xs, ys;
		logic [7:0]  din;
		if (k == 0) begin : g_first
			assign xin = hx;
			assign yin = hy;
			assign zin = '0;
			assign din = dsh_in;
		end else begin : g_next
			assign xin = hx_s[k-1];
			assign yin = hy_s[k-1];
			assign zin = hz_s[k-1];
			assign din = d_s[k-1];
		end
		assign xs = $signed(xin) >>> SH;
		assign ys = $signed(yin) >>> SH;
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k] <= din;
				if (yin[63]) begin
					hx_s[k] <= xin + ys;
					hy_s[k] <= yin + xs;
					hz_s[k] <= zin - ANG;
				end else begin
					hx_s[k] <= xin - ys;
					hy_s[k] <= yin - xs;
					hz_s[k] <= zin + ANG;
				end
			end
		end
	end

	assign hz      = hz_s[NH-1];
	assign dsh_out = d_s[NH-1];

endmodule

@@ sv/lwm_to_cm.sv @@
`timescale 1ns / 1ps

module lwm_to_cm
	import lwm_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	output logic [31:0] cm
);

	logic        n_s1, n_s2;
	logic [35:0] m32_s1;
	logic [63:0] prod_s2;
	logic [31:0] cm_s3;
	logic [63:0] mag;
	logic [63:0] rnd;
	logic [31:0] cmag;

	assign mag  = v[63] ? (64'd0 - v) : v;
	assign rnd  = mag + (64'd1 << 27);
	assign cmag = 32'((prod_s2 + (64'd1 << 31)) >> 32);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= v[63];
			m32_s1  <= rnd[63:28];
			n_s2    <= n_s1;
			prod_s2 <= 64'({28'd0, m32_s1} * R_CM);
			cm_s3   <= n_s2 ? (32'd0 - cmag) : cmag;
		end
	end

	assign cm = cm_s3;

endmodule

@@ sv/latlon_to_web_mercator_core.sv @@
`timescale 1ns / 1ps

// channel  | dir | payload  | handshake
// point    | in  | point_t  | point_valid / point_ready
// merc     | out | merc_t   | merc_valid / merc_ready
//
// one point per cycle while the output is not stalled; the pipe has one register per
// circular and per hyperbolic CORDIC iteration
// arst_n clears the valid bits only; data registers are not reset
// the whole pipe holds while the output register is full and not taken,
// so point_ready follows merc_ready combinationally

module latlon_to_web_mercator_core
	import lwm_pkg::*;
#(
	parameter int CORDIC_STEPS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   point_valid,
	output logic   point_ready,
	input  point_t point,
	output logic   merc_valid,
	input  logic   merc_ready,
	output merc_t  merc
);

	localparam int NH = hyp_count(CORDIC_STEPS);
	localparam int LY = CORDIC_STEPS + 3 + NH + 1 + 3;
	localparam int NV = 3 + LY + 1;
	localparam int XD = LY - 3;

	logic adv;
	logic [NV-1:0] vld_q;

	logic        oor_s1, lat_neg_s1, lon_neg_s1;
	logic [30:0] lat_abs_s1;
	logic [31:0] lon_abs_s1;
	logic        oor_s2, lat_neg_s2, lon_neg_s2;
	logic [63:0] lat_hi_s2, lat_lo_s2, lon_hi_s2, lon_lo_s2;
	logic        oor_s3;
	logic [63:0] theta_s3, lam_s3;
	logic [63:0] dlat, dlon;
	logic        lat_oor, lon_oor;

	logic [63:0] cos_v, sin_v, hx, hy, hz;
	logic [7:0]  dsh_n, dsh_h;
	logic [63:0] lval_s;
	logic [31:0] x_cm, y_cm;
	logic [31:0] xdly_s [XD];
	logic        odly_s [LY];
	merc_t       merc_q;

	assign adv         = !vld_q[NV-1] || merc_ready;
	assign point_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], point_valid};
		end
	end

	assign lat_oor = (point.latitude < -LAT_LIMIT) || (point.latitude > LAT_LIMIT);
	assign lon_oor = (point.longitude < -LON_LIMIT) || (point.longitude > LON_LIMIT);

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s1     <= lat_oor || lon_oor;
			lat_neg_s1 <= point.latitude[30];
			lon_neg_s1 <= point.longitude[31];
			lat_abs_s1 <= point.latitude[30] ? (31'd0 - point.latitude) : point.latitude;
			lon_abs_s1 <= point.longitude[31] ? (32'd0 - point.longitude) : point.longitude;
		end
	end

	// partial products of the degree to radian scaling
	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s2     <= oor_s1;
			lat_neg_s2 <= lat_neg_s1;
			lon_neg_s2 <= lon_neg_s1;
			lat_hi_s2  <= 64'({33'd0, lat_abs_s1} * F_HI);
			lat_lo_s2  <= 64'({33'd0, lat_abs_s1} * F_LO);
			lon_hi_s2  <= 64'({32'd0, lon_abs_s1} * F2_HI);
			lon_lo_s2  <= 64'({32'd0, lon_abs_s1} * F2_LO);
		end
	end

	assign dlat = (lat_hi_s2 << 2) + (lat_lo_s2 >> 30);
	assign dlon = (lon_hi_s2 << 2) + (lon_lo_s2 >> 30);

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s3   <= oor_s2;
			theta_s3 <= QPI_Q60 + (lat_neg_s2 ? (64'd0 - dlat) : dlat);
			lam_s3   <= lon_neg_s2 ? (64'd0 - dlon) : dlon;
		end
	end

	lwm_circ #(.STEPS(CORDIC_STEPS)) u_circ (
		.clk   (clk),
		.en    (adv),
		.theta (theta_s3),
		.cos_v (cos_v),
		.sin_v (sin_v)
	);

	lwm_norm u_norm (
		.clk   (clk),
		.en    (adv),
		.sin_v (sin_v),
		.cos_v (cos_v),
		.hx    (hx),
		.hy    (hy),
		.dsh   (dsh_n)
	);

	lwm_hyp #(.STEPS(CORDIC_STEPS)) u_hyp (
		.clk     (clk),
		.en      (adv),
		.hx      (hx),
		.hy      (hy),
		.dsh_in  (dsh_n),
		.hz      (hz),
		.dsh_out (dsh_h)
	);

	// ln(tan) = 2*atanh + exponent difference * ln2
	always_ff @(posedge clk) begin
		if (adv) begin
			lval_s <= {hz[62:0], 1'b0} + 64'($signed(dsh_h) * $signed({1'b0, LN2_Q60}));
		end
	end

	lwm_to_cm u_ycm (
		.clk (clk),
		.en  (adv),
		.v   (lval_s),
		.cm  (y_cm)
	);

	lwm_to_cm u_xcm (
		.clk (clk),
		.en  (adv),
		.v   (lam_s3),
		.cm  (x_cm)
	);

	// easting and range flag wait for the northing
	always_ff @(posedge clk) begin
		if (adv) begin
			xdly_s[0] <= x_cm;
			for (int i = 1; i < XD; i++) xdly_s[i] <= xdly_s[i-1];
			odly_s[0] <= oor_s3;
			for (int i = 1; i < LY; i++) odly_s[i] <= odly_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			merc_q.out_of_range <= odly_s[LY-1];
			merc_q.x_cm         <= odly_s[LY-1] ? '0 : xdly_s[XD-1];
			merc_q.y_cm         <= odly_s[LY-1] ? '0 : y_cm;
		end
	end

	assign merc_valid = vld_q[NV-1];
	assign merc       = merc_q;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		merc_valid && merc.out_of_range |-> merc.x_cm == 32'sd0 && merc.y_cm == 32'sd0)
		else $error("out of range transaction with nonzero coordinates");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		point_ready == (!merc_valid || merc_ready))
		else $error("input ready does not follow output stall");

	a_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		merc_valid |-> merc.x_cm <= 32'sd2003750835 && merc.x_cm >= -32'sd2003750835)
		else $error("easting beyond projection limit");

endmodule

@@ bench/merc_checker.sv @@
`timescale 1ns / 1ps

module merc_checker
	import lwm_pkg::*;
#(
	parameter int CORDIC_STEPS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   point_valid,
	input  logic   point_ready,
	input  point_t point,
	input  logic   merc_valid,
	input  logic   merc_ready,
	input  merc_t  merc,
	output int     fail_count,
	output int     pending
);

	logic [63:0] atan_q60 [64];
	logic [63:0] atanh_q60 [64];
	merc_t expected_q [$];

	function automatic logic [63:0] sra64(input logic [63:0] v, input int s);
		return $unsigned($signed(v) >>> s);
	endfunction

	// floor(a * b / 2^30) with 128-bit product
	function automatic logic [63:0] scale_deg(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[93:30];
	endfunction

	function automatic logic [31:0] q60_to_cm(input logic [63:0] v);
		logic [63:0] m;
		logic [63:0] m32;
		logic [127:0] cm;
		logic [63:0] r;
		m = v[63] ? (64'd0 - v) : v;
		m32 = (m + (64'd1 << 27)) >> 28;
		cm = ({64'd0, m32} * {64'd0, R_CM} + (128'd1 << 31)) >> 32;
		r = v[63] ? (64'd0 - cm[63:0]) : cm[63:0];
		return r[31:0];
	endfunction

	function automatic logic [63:0] norm_half(input logic [63:0] v, output int sh);
		int n;
		n = 0;
		if (v == 0 || v[63]) v = 1;
		while (v < HALF_Q60) begin
			v = v << 1;
			n++;
		end
		while (v >= (64'd1 << 60)) begin
			v = v >> 1;
			n--;
		end
		sh = n;
		return v;
	endfunction

	function automatic void hyp_rot(inout logic [63:0] x, inout logic [63:0] y,
		inout logic [63:0] z, input int i);
		logic [63:0] xs;
		logic [63:0] ys;
		xs = sra64(x, i);
		ys = sra64(y, i);
		if (y[63]) begin
			x = x + ys; y = y + xs; z = z - atanh_q60[i];
		end else begin
			x = x - ys; y = y - xs; z = z + atanh_q60[i];
		end
	endfunction

	function automatic merc_t project(input point_t p);
		merc_t r;
		logic signed [63:0] lat;
		logic signed [63:0] lon;
		logic [63:0] d, cx, cy, cz, xs, ys, ms, mc, hx, hy, hz, lv;
		int as_sh, ac_sh;
		lat = p.latitude;
		lon = p.longitude;
		r = '0;
		if (lat < -850511000 || lat > 850511000 || lon < -1800000000 || lon > 1800000000) begin
			r.out_of_range = 1'b1;
			return r;
		end
		d = scale_deg(lat < 0 ? -lat : lat, RAD_F);
		cz = QPI_Q60 + (lat < 0 ? (64'd0 - d) : d);
		cx = HALF_Q60;
		cy = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = sra64(cx, i);
			ys = sra64(cy, i);
			if (!cz[63]) begin
				cx = cx - ys; cy = cy + xs; cz = cz - atan_q60[i];
			end else begin
				cx = cx + ys; cy = cy - xs; cz = cz + atan_q60[i];
			end
		end
		ms = norm_half(cy, as_sh);
		mc = norm_half(cx, ac_sh);
		hx = ms + mc;
		hy = ms - mc;
		hz = 0;
		for (int i = 1; i <= CORDIC_STEPS; i++) begin
			hyp_rot(hx, hy, hz, i);
			if (i == 4 || i == 13 || i == 40) hyp_rot(hx, hy, hz, i);
		end
		lv = (hz << 1) + $unsigned(64'(signed'(ac_sh - as_sh))) * LN2_Q60;
		d = scale_deg(lon < 0 ? -lon : lon, RAD_F2);
		r.x_cm = q60_to_cm(lon < 0 ? (64'd0 - d) : d);
		r.y_cm = q60_to_cm(lv);
		return r;
	endfunction

	initial begin
		logic [63:0] sa, sh, term;
		int e;
		atan_q60[0] = QPI_Q60;
		atanh_q60[0] = 0;
		for (int i = 1; i < 64; i++) begin
			sa = 0;
			sh = 0;
			for (int k = 0; ; k++) begin
				e = i * (2 * k + 1);
				if (e > 60) break;
				term = (64'd1 << (60 - e)) / (2 * k + 1);
				sh = sh + term;
				if (k & 1) sa = sa - term;
				else sa = sa + term;
			end
			atan_q60[i] = sa;
			atanh_q60[i] = sh;
		end
	end

	always @(posedge clk) begin
		merc_t exp_r;
		if (arst_n) begin
			if (point_valid && point_ready) expected_q.push_back(project(point));
			if (merc_valid && merc_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no transaction pending: %h", merc);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (merc.x_cm !== exp_r.x_cm) begin
						$error("x_cm expected %0d got %0d", exp_r.x_cm, merc.x_cm);
						fail_count++;
					end
					if (merc.y_cm !== exp_r.y_cm) begin
						$error("y_cm expected %0d got %0d", exp_r.y_cm, merc.y_cm);
						fail_count++;
					end
					if (merc.out_of_range !== exp_r.out_of_range) begin
						$error("out_of_range expected %0d got %0d", exp_r.out_of_range,
							merc.out_of_range);
						fail_count++;
					end
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import lwm_pkg::*;

	localparam int STEPS = 32;
	localparam int N_RANDOM = 934;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   point_valid = 1'b0;
	logic   point_ready;
	point_t point = '0;
	logic   merc_valid;
	logic   merc_ready = 1'b0;
	merc_t  merc;
	int     fail_count;
	int     pending;
	int     send_idle_pct = 7;
	int     recv_idle_pct = 50;
	bit     recv_hold = 1'b0;

	always #5 clk = ~clk;

	latlon_to_web_mercator_core #(.CORDIC_STEPS(STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_ready(point_ready), .point(point),
		.merc_valid(merc_valid), .merc_ready(merc_ready), .merc(merc)
	);

	merc_checker #(.CORDIC_STEPS(STEPS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_ready(point_ready), .point(point),
		.merc_valid(merc_valid), .merc_ready(merc_ready), .merc(merc),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver stalls
	always @(negedge clk) begin
		if (recv_hold) merc_ready <= 1'b0;
		else merc_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_point(input logic signed [30:0] lat, input logic signed [31:0] lon);
		while ($urandom_range(99) < send_idle_pct) begin
			point_valid <= 1'b0;
			@(negedge clk);
		end
		point_valid <= 1'b1;
		point.latitude <= lat;
		point.longitude <= lon;
		@(posedge clk);
		while (!point_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		point_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic random_point();
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		case ($urandom_range(9))
			0: begin
				lat = 31'($urandom);
				lon = $urandom;
			end
			1: begin
				lat = 31'($urandom_range(100) - 50 +
					(($urandom_range(1)) ? 850511000 : -850511000));
				lon = $urandom_range(100) - 50 + (($urandom_range(1)) ? 1800000000 : -1800000000);
			end
			default: begin
				lat = 31'($signed($urandom_range(1701022000)) - 850511000);
				lon = $signed($urandom_range(2000000000)) - 1000000000;
				lon = lon + lon / 1000 * 800;
			end
		endcase
		send_point(lat, lon);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_point(31'sd0, 32'sd0);
		send_point(31'sd850511000, 32'sd1800000000);
		send_point(-31'sd850511000, -32'sd1800000000);
		send_point(31'sd850511001, 32'sd0);
		send_point(-31'sd850511001, 32'sd0);
		send_point(31'sd0, 32'sd1800000001);
		send_point(31'sd0, -32'sd1800000001);
		send_point(31'sd900000000, 32'sd1800000000);
		send_point(-31'sd900000000, -32'sd1800000000);
		send_point(31'h3FFFFFFF, 32'h7FFFFFFF);
		send_point(31'h40000000, 32'h80000000);
		send_point(-31'sd1, -32'sd1);
		send_point(31'sd1, 32'sd1);
		send_point(31'sd450000000, -32'sd900000000);
		send_point(-31'sd450000000, 32'sd900000000);
		send_point(31'sd515000000, -32'sd1270000);
		drain();

		// long receiver hold while points keep coming
		recv_hold = 1'b1;
		fork
			begin
				repeat (200) @(negedge clk);
				recv_hold = 1'b0;
			end
			repeat (150) random_point();
		join
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 50;
				recv_idle_pct = 7;
			end else if (i == 2 * N_RANDOM / 3) begin
				drain();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_point();
		end
		drain();
		repeat (4 * STEPS + 40) @(negedge clk);

		if (fail_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
